FILE: rtl/core/skw_pkg.sv
// shared types and constants of the self-keying word stream cipher
`timescale 1ns / 1ps

package skw_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned KIDX_W = 5;
  localparam int unsigned KLEN_W = 5;
  localparam int unsigned CFG_IW = 1;
  localparam int unsigned CFG_DW = 5;
  localparam int unsigned DIV_CW = 6;

  localparam logic [DIV_CW-1:0] DIV_STEPS = 6'd32;

  // configuration register indexes
  localparam logic [CFG_IW-1:0] CFG_KEY_LENGTH = 1'b0;
  localparam logic [CFG_IW-1:0] CFG_DIRECTION  = 1'b1;

  // input word modes
  localparam logic MODE_KEY  = 1'b0;
  localparam logic MODE_DATA = 1'b1;

  localparam logic DIR_ENCRYPT = 1'b1;

  localparam logic [KLEN_W-1:0] KEY_LENGTH_RST = 5'd31;

  // remainder operations, in the order they run
  typedef enum logic [2:0] {
    OP_KA,
    OP_KB,
    OP_KC,
    OP_PA,
    OP_PB,
    OP_PC,
    OP_CS
  } skw_op_e;

  // key store read address select
  typedef enum logic [2:0] {
    RS_OP,
    RS_PA,
    RS_PB,
    RS_PC,
    RS_CS
  } skw_rsel_e;

  typedef struct packed {
    skw_op_e   op;
    skw_rsel_e rd_sel;
    logic      div_start;
    logic      div_wait;
    logic      cap_mix;
    logic      cap_res;
    logic      wr_rot;
    logic      wr_fold;
    logic      wr_cnt;
    logic      commit;
    logic      out_load;
  } skw_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_busy;
  } skw_stat_t;

endpackage

FILE: rtl/core/skw_div.sv
// serial remainder unit, one dividend bit per cycle
`timescale 1ns / 1ps

module skw_div #(
  parameter int unsigned DW = 5
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [skw_pkg::WORD_W-1:0] dividend_i,
  input  logic [DW-1:0]             divisor_i,
  output logic [DW-1:0]             rem_o,
  output logic                      done_o
);

  logic                        active_q;
  logic                        done_q;
  logic [skw_pkg::DIV_CW-1:0]  cnt_q;
  logic [skw_pkg::WORD_W-1:0]  num_q;
  logic [DW-1:0]               rem_q;
  logic [DW-1:0]               rem_d;
  logic [DW:0]                 trial;

  // restoring step: bring in the next bit, subtract if it fits
  always_comb begin
    trial = {rem_q, num_q[skw_pkg::WORD_W-1]};
    if (trial >= {1'b0, divisor_i}) begin
      rem_d = DW'(trial - {1'b0, divisor_i});
    end else begin
      rem_d = DW'(trial);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        active_q <= 1'b1;
        cnt_q    <= skw_pkg::DIV_STEPS;
      end else if (active_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == skw_pkg::DIV_CW'(1)) begin
          active_q <= 1'b0;
          done_q   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      rem_q <= '0;
    end else if (active_q) begin
      num_q <= num_q << 1;
      rem_q <= rem_d;
    end
  end

  assign rem_o  = rem_q;
  assign done_o = done_q;

endmodule

FILE: rtl/core/skw_dp.sv
// datapath: key store, pointers, counter, config registers and output register
`timescale 1ns / 1ps

module skw_dp #(
  parameter int unsigned MAX_KEY_WORDS = 31
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  skw_pkg::skw_cmd_t           cmd_i,
  output skw_pkg::skw_stat_t          stat_o,
  input  logic                        in_accept_i,
  input  logic                        mode_i,
  input  logic [skw_pkg::KIDX_W-1:0]  key_index_i,
  input  logic [skw_pkg::WORD_W-1:0]  word_i,
  input  logic                        start_of_message_i,
  input  logic                        cfg_we_i,
  input  logic [skw_pkg::CFG_IW-1:0]  cfg_index_i,
  input  logic [skw_pkg::CFG_DW-1:0]  cfg_data_i,
  input  logic                        out_stall_i,
  output logic                        out_valid_o,
  output logic [skw_pkg::WORD_W-1:0]  data_out_o
);

  localparam int unsigned IW = $clog2(MAX_KEY_WORDS);
  localparam int unsigned DW = $clog2(MAX_KEY_WORDS + 1);

  logic [skw_pkg::WORD_W-1:0] mem [MAX_KEY_WORDS];
  logic [skw_pkg::WORD_W-1:0] rdata_q;

  logic [skw_pkg::KLEN_W-1:0] key_length_q;
  logic                       direction_q;
  logic [IW-1:0]              ptr_a_q, ptr_b_q, ptr_c_q;
  logic [IW-1:0]              pa_q, pb_q, pc_q;
  logic [IW-1:0]              slot_q;
  logic [skw_pkg::WORD_W-1:0] cnt_q;
  logic [skw_pkg::WORD_W-1:0] word_q, tmp_q, res_q;
  logic                       out_valid_q;
  logic [skw_pkg::WORD_W-1:0] out_data_q;

  logic [DW-1:0]              len_n;
  logic [31:0]                kl_ext;
  logic [IW-1:0]              rd_addr;
  logic                       wr_en;
  logic [IW-1:0]              wr_addr;
  logic [skw_pkg::WORD_W-1:0] wr_data;
  logic [skw_pkg::WORD_W-1:0] rot;
  logic [skw_pkg::WORD_W-1:0] fb;
  logic                       key_wr;
  logic [skw_pkg::WORD_W-1:0] div_num;
  logic [DW-1:0]              div_den;
  logic [DW-1:0]              div_rem;
  logic                       div_done;
  logic                       store;

  // (p + 1 + r) mod n, with p < n and r < n - 1
  function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] p,
                                             input logic [DW-1:0] r,
                                             input logic [DW-1:0] n);
    logic [DW:0] s;
    s = (DW+1)'(p) + (DW+1)'(r) + (DW+1)'(1);
    if (s >= (DW+1)'(n)) begin
      s = s - (DW+1)'(n);
    end
    return IW'(s);
  endfunction

  // effective key length, saturated to 2..MAX_KEY_WORDS
  always_comb begin
    kl_ext = 32'(key_length_q);
    if (kl_ext < 32'd2) begin
      len_n = DW'(2);
    end else if (kl_ext > 32'(MAX_KEY_WORDS)) begin
      len_n = DW'(MAX_KEY_WORDS);
    end else begin
      len_n = DW'(kl_ext);
    end
  end

  assign key_wr = in_accept_i && (mode_i == skw_pkg::MODE_KEY) &&
                  (32'(key_index_i) < 32'(MAX_KEY_WORDS));
  assign rot    = {rdata_q[skw_pkg::WORD_W-2:0], rdata_q[skw_pkg::WORD_W-1]};
  assign fb     = (direction_q == skw_pkg::DIR_ENCRYPT) ? res_q : word_q;

  always_comb begin
    case (cmd_i.op)
      skw_pkg::OP_KA: rd_addr = IW'(0);
      skw_pkg::OP_KB: rd_addr = IW'(1);
      skw_pkg::OP_KC: rd_addr = IW'(2);
      skw_pkg::OP_PA: rd_addr = ptr_b_q;
      skw_pkg::OP_PB: rd_addr = ptr_c_q;
      skw_pkg::OP_PC: rd_addr = ptr_a_q;
      default:        rd_addr = ptr_a_q;
    endcase
    case (cmd_i.rd_sel)
      skw_pkg::RS_PA: rd_addr = pa_q;
      skw_pkg::RS_PB: rd_addr = pb_q;
      skw_pkg::RS_PC: rd_addr = pc_q;
      skw_pkg::RS_CS: rd_addr = slot_q;
      default:        ;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = IW'(key_index_i);
    wr_data = word_i;
    if (key_wr) begin
      wr_en = 1'b1;
    end else if (cmd_i.wr_rot) begin
      wr_en   = 1'b1;
      wr_addr = pc_q;
      wr_data = rot;
    end else if (cmd_i.wr_fold) begin
      wr_en   = 1'b1;
      wr_addr = pa_q;
      wr_data = rdata_q ^ tmp_q ^ fb;
    end else if (cmd_i.wr_cnt) begin
      wr_en   = 1'b1;
      wr_addr = slot_q;
      wr_data = rdata_q ^ cnt_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_q <= mem[rd_addr];
  end

  // remainder unit operands
  assign div_num = (cmd_i.op == skw_pkg::OP_CS) ? cnt_q : rdata_q;
  assign div_den = (cmd_i.op == skw_pkg::OP_PB || cmd_i.op == skw_pkg::OP_PC) ?
                   len_n - DW'(1) : len_n;

  skw_div #(
    .DW (DW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .rem_o      (div_rem),
    .done_o     (div_done)
  );

  assign store = cmd_i.div_wait && div_done;

  // architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_length_q <= skw_pkg::KEY_LENGTH_RST;
      direction_q  <= skw_pkg::DIR_ENCRYPT;
      ptr_a_q      <= '0;
      ptr_b_q      <= '0;
      ptr_c_q      <= '0;
      slot_q       <= '0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == skw_pkg::CFG_KEY_LENGTH) begin
          key_length_q <= cfg_data_i;
        end else begin
          direction_q <= cfg_data_i[0];
        end
      end
      if (in_accept_i && mode_i == skw_pkg::MODE_DATA && start_of_message_i) begin
        cnt_q <= '0;
      end
      if (store) begin
        case (cmd_i.op)
          skw_pkg::OP_KA: ptr_a_q <= IW'(div_rem);
          skw_pkg::OP_KB: ptr_b_q <= IW'(div_rem);
          skw_pkg::OP_KC: ptr_c_q <= IW'(div_rem);
          skw_pkg::OP_CS: slot_q  <= IW'(div_rem);
          default:        ;
        endcase
      end
      if (cmd_i.commit) begin
        ptr_a_q <= pa_q;
        ptr_b_q <= pb_q;
        ptr_c_q <= pc_q;
        cnt_q   <= cnt_q + 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (in_accept_i) begin
      word_q <= word_i;
    end
    if (store) begin
      case (cmd_i.op)
        skw_pkg::OP_PA: pa_q <= IW'(div_rem);
        skw_pkg::OP_PB: pb_q <= wrap_add(pa_q, div_rem, len_n);
        skw_pkg::OP_PC: pc_q <= wrap_add(pa_q, div_rem, len_n);
        default:        ;
      endcase
    end
    if (cmd_i.cap_mix) begin
      tmp_q <= word_q ^ rdata_q;
    end else if (cmd_i.wr_rot) begin
      tmp_q <= rot;
    end
    if (cmd_i.cap_res) begin
      res_q <= tmp_q ^ rdata_q;
    end
    if (cmd_i.out_load) begin
      out_data_q <= res_q;
    end
  end

  assign stat_o.div_done = div_done;
  assign stat_o.out_busy = out_valid_q && out_stall_i;
  assign out_valid_o     = out_valid_q;
  assign data_out_o      = out_data_q;

endmodule

FILE: rtl/core/skw_ctrl.sv
// controller: sequences the remainder operations and key store updates
`timescale 1ns / 1ps

module skw_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                mode_i,
  input  logic                start_of_message_i,
  input  skw_pkg::skw_stat_t  stat_i,
  output skw_pkg::skw_cmd_t   cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DREAD,
    S_DSTART,
    S_DWAIT,
    S_RD_A,
    S_RD_B,
    S_RD_C,
    S_ROT,
    S_RD_A2,
    S_FOLD,
    S_RD_S,
    S_CNT,
    S_DONE
  } state_e;

  state_e           state_q;
  skw_pkg::skw_op_e op_q;
  logic             accept;

  function automatic skw_pkg::skw_op_e next_op(input skw_pkg::skw_op_e op);
    case (op)
      skw_pkg::OP_KA: return skw_pkg::OP_KB;
      skw_pkg::OP_KB: return skw_pkg::OP_KC;
      skw_pkg::OP_KC: return skw_pkg::OP_PA;
      skw_pkg::OP_PA: return skw_pkg::OP_PB;
      skw_pkg::OP_PB: return skw_pkg::OP_PC;
      default:        return skw_pkg::OP_CS;
    endcase
  endfunction

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= skw_pkg::OP_PA;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept && mode_i == skw_pkg::MODE_DATA) begin
            state_q <= S_DREAD;
            op_q    <= start_of_message_i ? skw_pkg::OP_KA : skw_pkg::OP_PA;
          end
        end
        S_DREAD:  state_q <= S_DSTART;
        S_DSTART: state_q <= S_DWAIT;
        S_DWAIT: begin
          if (stat_i.div_done) begin
            if (op_q == skw_pkg::OP_CS) begin
              state_q <= S_RD_A;
            end else begin
              op_q    <= next_op(op_q);
              state_q <= S_DREAD;
            end
          end
        end
        S_RD_A:  state_q <= S_RD_B;
        S_RD_B:  state_q <= S_RD_C;
        S_RD_C:  state_q <= S_ROT;
        S_ROT:   state_q <= S_RD_A2;
        S_RD_A2: state_q <= S_FOLD;
        S_FOLD:  state_q <= S_RD_S;
        S_RD_S:  state_q <= S_CNT;
        S_CNT:   state_q <= S_DONE;
        S_DONE: begin
          if (!stat_i.out_busy) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.op     = op_q;
    cmd_o.rd_sel = skw_pkg::RS_OP;
    case (state_q)
      S_DSTART: cmd_o.div_start = 1'b1;
      S_DWAIT:  cmd_o.div_wait  = 1'b1;
      S_RD_A:   cmd_o.rd_sel    = skw_pkg::RS_PA;
      S_RD_B: begin
        cmd_o.rd_sel  = skw_pkg::RS_PB;
        cmd_o.cap_mix = 1'b1;
      end
      S_RD_C: begin
        cmd_o.rd_sel  = skw_pkg::RS_PC;
        cmd_o.cap_res = 1'b1;
      end
      S_ROT:    cmd_o.wr_rot  = 1'b1;
      S_RD_A2:  cmd_o.rd_sel  = skw_pkg::RS_PA;
      S_FOLD:   cmd_o.wr_fold = 1'b1;
      S_RD_S:   cmd_o.rd_sel  = skw_pkg::RS_CS;
      S_CNT: begin
        cmd_o.wr_cnt = 1'b1;
        cmd_o.commit = 1'b1;
      end
      S_DONE:   cmd_o.out_load = !stat_i.out_busy;
      default:  ;
    endcase
  end

endmodule

FILE: rtl/core/self_keying_word_stream_cipher_unit.sv
// top level of the self-keying word stream cipher
`timescale 1ns / 1ps

// stream cipher on 32-bit words whose key store changes with every data word.
// a key word (mode 0) is written into the key store in the cycle it is taken
// and gives no result; a data word (mode 1) gives one result word. each data
// word needs four reductions modulo the key length (or the key length minus
// one), all done by one serial remainder unit at one bit per cycle, and seven
// reductions when start of message is set (three more to reload the pointers).
// the key store is a single-port-read memory with registered read data; the
// final key updates run as eight short read/write steps after the reductions.
// the input stalls while a data word is in flight; a finished word sits in the
// output register, so the next input is taken while the result waits.
// the key store has no reset: a data word that reads a never-written key word
// gives an undefined result. the user must write configuration only while
// idle; the block itself does not enforce it.

module self_keying_word_stream_cipher_unit #(
  parameter int unsigned MAX_KEY_WORDS = 31
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input words
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        mode_i,
  input  logic [skw_pkg::KIDX_W-1:0]  key_index_i,
  input  logic [skw_pkg::WORD_W-1:0]  word_i,
  input  logic                        start_of_message_i,
  // result words
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [skw_pkg::WORD_W-1:0]  data_out_o,
  // configuration writes
  input  logic                        cfg_we_i,
  input  logic [skw_pkg::CFG_IW-1:0]  cfg_index_i,
  input  logic [skw_pkg::CFG_DW-1:0]  cfg_data_i
);

  skw_pkg::skw_cmd_t  cmd;
  skw_pkg::skw_stat_t stat;
  logic               in_accept;

  assign in_accept = in_valid_i && !in_stall_o;

  // sequencer
  skw_ctrl u_ctrl (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .mode_i             (mode_i),
    .start_of_message_i (start_of_message_i),
    .stat_i             (stat),
    .cmd_o              (cmd)
  );

  // key store, pointers, counter and remainder unit
  skw_dp #(
    .MAX_KEY_WORDS (MAX_KEY_WORDS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .in_accept_i        (in_accept),
    .mode_i             (mode_i),
    .key_index_i        (key_index_i),
    .word_i             (word_i),
    .start_of_message_i (start_of_message_i),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .out_stall_i        (out_stall_i),
    .out_valid_o        (out_valid_o),
    .data_out_o         (data_out_o)
  );

  // a data word always makes the block busy in the next cycle
  a_data_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && mode_i == skw_pkg::MODE_DATA) |=> in_stall_o)
    else $error("data word accepted but block not busy");

  // the remainder unit never finishes in the cycle after a start
  a_div_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |=> !stat.div_done)
    else $error("remainder unit finished too early");

  // a finished remainder is only ever seen while the sequencer waits for it
  a_div_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.div_done |-> cmd.div_wait)
    else $error("remainder finished outside the wait state");

  // a new result word appears only after an output load
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.out_load))
    else $error("result word appeared without a load");

endmodule
